### rtl/crcfr_pkg.sv
// ----------------------------------------------------------------------------
// crcfr_pkg
// Shared types, constants and the byte-wise CRC-16/CCITT update for the
// framed packet receiver.
// ----------------------------------------------------------------------------
package crcfr_pkg;

  localparam int MaxPayload = 768;
  localparam int LenW       = 10;
  localparam int TickW      = 16;

  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'h1021;
  localparam logic [15:0] TimeoutReset = 16'd1000;

  // configuration register indexes
  localparam logic [1:0] RegPreamble = 2'd0;
  localparam logic [1:0] RegTimeout  = 2'd1;
  localparam logic [1:0] RegGarbage  = 2'd2;

  typedef enum logic [2:0] {
    PH_PREAMBLE = 3'd0,
    PH_GARBAGE  = 3'd1,
    PH_HDR      = 3'd2,
    PH_LEN      = 3'd3,
    PH_DATA     = 3'd4,
    PH_CRC_HI   = 3'd5,
    PH_CRC_LO   = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_PASS    = 3'd1,
    EV_PAYLOAD = 3'd2,
    EV_OK      = 3'd3,
    EV_BADCRC  = 3'd4,
    EV_TIMEOUT = 3'd5,
    EV_GARBAGE = 3'd6
  } event_t;

  typedef struct packed {
    event_t            event_res;
    logic [7:0]        out_byte;
    logic [1:0]        frame_type;
    logic [3:0]        seq_number;
    logic [LenW-1:0]   frame_length;
    logic [LenW-1:0]   byte_index;
  } result_t;

  // one byte through CRC-16/CCITT, MSB first, no reflection
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CrcPoly;
      else       c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

### rtl/crcfr_parser.sv
// ----------------------------------------------------------------------------
// crcfr_parser
// Configuration registers, frame parse state, CRC and receive timer. Builds
// the result for the item presented and updates state when it is accepted.
// ----------------------------------------------------------------------------
module crcfr_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_fire,
  input  logic                 func,
  input  logic [7:0]           rx_byte,
  output crcfr_pkg::result_t   res
);

  logic [7:0]  preamble_byte;
  logic [15:0] rx_timeout_ticks;
  logic        report_garbage;

  crcfr_pkg::phase_t parse_phase, parse_phase_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  trailer_high, trailer_high_next;
  logic [1:0]  held_type, held_type_next;
  logic [3:0]  held_seq, held_seq_next;
  logic [crcfr_pkg::LenW-1:0] held_length, held_length_next;
  logic [crcfr_pkg::LenW-1:0] payload_count, payload_count_next;
  logic        timer_active, timer_active_next;
  logic [crcfr_pkg::TickW-1:0] tick_count, tick_count_next;

  logic [crcfr_pkg::LenW:0] len_raw, len_sat;
  logic [1:0]  len_hi_m1;
  logic [15:0] crc_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      preamble_byte    <= 8'h00;
      rx_timeout_ticks <= crcfr_pkg::TimeoutReset;
      report_garbage   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        crcfr_pkg::RegPreamble: preamble_byte    <= cfg_data[7:0];
        crcfr_pkg::RegTimeout:  rx_timeout_ticks <= cfg_data;
        crcfr_pkg::RegGarbage:  report_garbage   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase   <= crcfr_pkg::PH_PREAMBLE;
      running_crc   <= crcfr_pkg::CrcInit;
      trailer_high  <= 8'h00;
      held_type     <= 2'd0;
      held_seq      <= 4'd0;
      held_length   <= '0;
      payload_count <= '0;
      timer_active  <= 1'b0;
      tick_count    <= '0;
    end else if (in_fire) begin
      parse_phase   <= parse_phase_next;
      running_crc   <= running_crc_next;
      trailer_high  <= trailer_high_next;
      held_type     <= held_type_next;
      held_seq      <= held_seq_next;
      held_length   <= held_length_next;
      payload_count <= payload_count_next;
      timer_active  <= timer_active_next;
      tick_count    <= tick_count_next;
    end
  end

  // length decode: ((hi-1)<<8 | lo) + 1, saturated
  assign len_hi_m1 = held_length[1:0] - 2'd1;
  assign len_raw   = {1'b0, len_hi_m1, rx_byte} + {{crcfr_pkg::LenW{1'b0}}, 1'b1};
  assign len_sat   = (len_raw > (crcfr_pkg::LenW+1)'(crcfr_pkg::MaxPayload))
                   ? (crcfr_pkg::LenW+1)'(crcfr_pkg::MaxPayload) : len_raw;
  assign crc_step  = crcfr_pkg::crc_byte(
                       (parse_phase == crcfr_pkg::PH_HDR) ? crcfr_pkg::CrcInit : running_crc,
                       rx_byte);

  always_comb begin
    parse_phase_next   = parse_phase;
    running_crc_next   = running_crc;
    trailer_high_next  = trailer_high;
    held_type_next     = held_type;
    held_seq_next      = held_seq;
    held_length_next   = held_length;
    payload_count_next = payload_count;
    timer_active_next  = timer_active;
    tick_count_next    = tick_count;
    res.event_res      = crcfr_pkg::EV_NONE;
    res.out_byte       = 8'h00;
    res.byte_index     = '0;

    if (func) begin
      if (timer_active) begin
        if (tick_count != {crcfr_pkg::TickW{1'b1}}) tick_count_next = tick_count + 1'b1;
        if (tick_count_next >= rx_timeout_ticks) begin
          timer_active_next = 1'b0;
          parse_phase_next  = crcfr_pkg::PH_PREAMBLE;
          res.event_res     = crcfr_pkg::EV_TIMEOUT;
        end
      end
    end else begin
      unique case (parse_phase)
        crcfr_pkg::PH_GARBAGE: begin
          if (rx_byte == preamble_byte) begin
            held_seq_next     = 4'd0;
            timer_active_next = 1'b1;
            tick_count_next   = '0;
            parse_phase_next  = crcfr_pkg::PH_HDR;
            if (report_garbage) res.event_res = crcfr_pkg::EV_GARBAGE;
          end else begin
            res.event_res = crcfr_pkg::EV_PASS;
            res.out_byte  = rx_byte;
          end
        end
        crcfr_pkg::PH_HDR: begin
          held_type_next   = rx_byte[7:6];
          held_seq_next    = rx_byte[5:2];
          held_length_next = {{(crcfr_pkg::LenW-2){1'b0}}, rx_byte[1:0]};
          running_crc_next = crc_step;
          parse_phase_next = (rx_byte[1:0] == 2'd0) ? crcfr_pkg::PH_CRC_HI
                                                   : crcfr_pkg::PH_LEN;
        end
        crcfr_pkg::PH_LEN: begin
          held_length_next   = len_sat[crcfr_pkg::LenW-1:0];
          running_crc_next   = crc_step;
          payload_count_next = '0;
          parse_phase_next   = (len_sat[crcfr_pkg::LenW-1:0] == '0)
                             ? crcfr_pkg::PH_CRC_HI : crcfr_pkg::PH_DATA;
        end
        crcfr_pkg::PH_DATA: begin
          res.event_res      = crcfr_pkg::EV_PAYLOAD;
          res.out_byte       = rx_byte;
          res.byte_index     = payload_count;
          running_crc_next   = crc_step;
          payload_count_next = payload_count + 1'b1;
          if (payload_count_next >= held_length) parse_phase_next = crcfr_pkg::PH_CRC_HI;
        end
        crcfr_pkg::PH_CRC_HI: begin
          trailer_high_next = rx_byte;
          parse_phase_next  = crcfr_pkg::PH_CRC_LO;
        end
        crcfr_pkg::PH_CRC_LO: begin
          timer_active_next = 1'b0;
          parse_phase_next  = crcfr_pkg::PH_PREAMBLE;
          res.event_res     = ({trailer_high, rx_byte} == running_crc)
                            ? crcfr_pkg::EV_OK : crcfr_pkg::EV_BADCRC;
        end
        default: begin
          // expecting preamble (also the unused phase code)
          if (rx_byte == preamble_byte) begin
            held_seq_next     = 4'd0;
            timer_active_next = 1'b1;
            tick_count_next   = '0;
            parse_phase_next  = crcfr_pkg::PH_HDR;
          end else begin
            parse_phase_next = crcfr_pkg::PH_GARBAGE;
            res.event_res    = crcfr_pkg::EV_PASS;
            res.out_byte     = rx_byte;
          end
        end
      endcase
    end

    // held fields report their post-update values
    res.frame_type   = held_type_next;
    res.seq_number   = held_seq_next;
    res.frame_length = held_length_next;
  end

endmodule

### rtl/crcfr_out_reg.sv
// ----------------------------------------------------------------------------
// crcfr_out_reg
// Result register with valid flag; packs the result onto the master stream.
// ----------------------------------------------------------------------------
module crcfr_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  crcfr_pkg::result_t  res_in,
  input  logic                m_tready,
  output logic                m_tvalid,
  output logic [39:0]         m_tdata,
  output logic [2:0]          m_tuser
);

  crcfr_pkg::result_t res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_q <= res_in;
  end

  assign m_tuser = res_q.event_res;
  assign m_tdata = {6'd0, res_q.byte_index, res_q.frame_length, res_q.seq_number,
                    res_q.frame_type, res_q.out_byte};

endmodule

### rtl/crc16_framed_packet_receiver.sv
// Output: the result word for an accepted word is registered and shown on the master side in the next cycle.
// Throughput: one word per cycle while the result register is empty or being taken; the
//   parse state, CRC byte update and timer step all complete in the cycle the word is accepted.
// Reset (rst, synchronous, active high): parser waits for a preamble, CRC at
//   0xFFFF, held fields and timer cleared, registers at their defaults.
// ----------------------------------------------------------------------------
// crc16_framed_packet_receiver
// Framed packet receiver: preamble hunt, header/length decode, payload
// streaming, CRC-16/CCITT trailer check and receive timeout.
// ----------------------------------------------------------------------------
module crc16_framed_packet_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] out_byte, [9:8] frame_type, [13:10] seq_number,
                                 // [23:14] frame_length, [33:24] byte_index, rest zero
  output logic [2:0]  m_tuser    // [2:0] event_res
);

  crcfr_pkg::result_t res;
  logic in_fire;

  assign s_tready = !m_tvalid || m_tready;
  assign in_fire  = s_tvalid && s_tready;

  crcfr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_fire   (in_fire),
    .func      (s_tuser),
    .rx_byte   (s_tdata),
    .res       (res)
  );

  crcfr_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (in_fire),
    .res_in   (res),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

### tb/crc16_frame_checker.sv
// ----------------------------------------------------------------------------
// crc16_frame_checker
// Watches both streams and the register port of the framed packet receiver.
// It keeps its own parser state and CRC, predicts one result word per input
// word and compares the results in order as they leave the block.
// ----------------------------------------------------------------------------
module crc16_frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] func
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // [7:0] out_byte, [9:8] frame_type, [13:10] seq_number,
                                 // [23:14] frame_length, [33:24] byte_index, rest zero
  input  logic [2:0]  m_tuser,   // [2:0] event_res
  output int          fail_count,
  output int          pending,
  output int          checked,
  output logic [15:0] frame_crc
);
  timeunit 1ns;
  timeprecision 1ps;
  import crcfr_pkg::*;

  // register copies
  logic [7:0]  cfg_pre;
  logic [15:0] cfg_tmo;
  logic        cfg_garb;

  // parser copy
  phase_t      rx_phase;
  logic [15:0] crc_acc;
  logic [7:0]  trail_hi;
  logic [1:0]  hold_type;
  logic [3:0]  hold_seq;
  logic [9:0]  hold_len;
  logic [9:0]  pay_cnt;
  logic        timer_on;
  logic [15:0] ticks;

  result_t     due_results[$];
  result_t     want;
  logic [39:0] want_data;
  int          n_fail = 0;
  int          n_checked = 0;
  int          n_pending = 0;

  assign fail_count = n_fail;
  assign pending    = n_pending;
  assign checked    = n_checked;
  assign frame_crc  = crc_acc;

  // bit-serial form of the CCITT update, MSB first
  function automatic logic [15:0] ccitt_update(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ d[i];
      r  = {r[14:0], 1'b0};
      if (fb) r = r ^ CrcPoly;
    end
    return r;
  endfunction

  function automatic void open_frame();
    hold_seq = 4'd0;
    timer_on = 1'b1;
    ticks    = 16'd0;
    rx_phase = PH_HDR;
  endfunction

  function automatic result_t parse_word(input logic is_tick, input logic [7:0] c);
    result_t     r;
    event_t      ev;
    logic [7:0]  ob;
    logic [9:0]  idx;
    logic [1:0]  hm1;
    logic [10:0] len;
    ev  = EV_NONE;
    ob  = 8'd0;
    idx = 10'd0;
    if (is_tick) begin
      if (timer_on) begin
        if (ticks != 16'hFFFF) ticks = ticks + 16'd1;
        if (ticks >= cfg_tmo) begin
          timer_on = 1'b0;
          rx_phase = PH_PREAMBLE;
          ev       = EV_TIMEOUT;
        end
      end
    end else begin
      case (rx_phase)
        PH_GARBAGE: begin
          if (c == cfg_pre) begin
            open_frame();
            if (cfg_garb) ev = EV_GARBAGE;
          end else begin
            ev = EV_PASS;
            ob = c;
          end
        end
        PH_HDR: begin
          hold_type = c[7:6];
          hold_seq  = c[5:2];
          hold_len  = {8'd0, c[1:0]};  // raw length bits until the length word
          crc_acc   = ccitt_update(CrcInit, c);
          rx_phase  = (c[1:0] == 2'd0) ? PH_CRC_HI : PH_LEN;
        end
        PH_LEN: begin
          hm1 = hold_len[1:0] - 2'd1;
          len = {1'b0, hm1, c} + 11'd1;
          if (len > 11'(MaxPayload)) len = 11'(MaxPayload);
          hold_len = len[9:0];
          crc_acc  = ccitt_update(crc_acc, c);
          pay_cnt  = 10'd0;
          rx_phase = (hold_len == 10'd0) ? PH_CRC_HI : PH_DATA;
        end
        PH_DATA: begin
          ev      = EV_PAYLOAD;
          ob      = c;
          idx     = pay_cnt;
          crc_acc = ccitt_update(crc_acc, c);
          pay_cnt = pay_cnt + 10'd1;
          if (pay_cnt >= hold_len) rx_phase = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          trail_hi = c;
          rx_phase = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          timer_on = 1'b0;
          ev       = ({trail_hi, c} == crc_acc) ? EV_OK : EV_BADCRC;
          rx_phase = PH_PREAMBLE;
        end
        default: begin
          if (c == cfg_pre) begin
            open_frame();
          end else begin
            rx_phase = PH_GARBAGE;
            ev       = EV_PASS;
            ob       = c;
          end
        end
      endcase
    end
    r.event_res    = ev;
    r.out_byte     = ob;
    r.frame_type   = hold_type;
    r.seq_number   = hold_seq;
    r.frame_length = hold_len;
    r.byte_index   = idx;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cfg_pre   = 8'd0;
      cfg_tmo   = TimeoutReset;
      cfg_garb  = 1'b0;
      rx_phase  = PH_PREAMBLE;
      crc_acc   = CrcInit;
      trail_hi  = 8'd0;
      hold_type = 2'd0;
      hold_seq  = 4'd0;
      hold_len  = 10'd0;
      pay_cnt   = 10'd0;
      timer_on  = 1'b0;
      ticks     = 16'd0;
      due_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegPreamble: cfg_pre  = cfg_data[7:0];
          RegTimeout:  cfg_tmo  = cfg_data;
          RegGarbage:  cfg_garb = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) due_results.push_back(parse_word(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        if (due_results.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("[%0t] result word with nothing outstanding: ev %0d data %h",
                     $realtime, m_tuser, m_tdata);
        end else begin
          want      = due_results.pop_front();
          want_data = {6'd0, want.byte_index, want.frame_length, want.seq_number,
                       want.frame_type, want.out_byte};
          n_checked++;
          if (m_tuser !== want.event_res || m_tdata !== want_data) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("[%0t] result %0d mismatch", $realtime, n_checked);
              $display("  exp ev %0d byte %h type %0d seq %0d len %0d idx %0d",
                       want.event_res, want.out_byte, want.frame_type,
                       want.seq_number, want.frame_length, want.byte_index);
              $display("  got ev %0d byte %h type %0d seq %0d len %0d idx %0d pad %h",
                       m_tuser, m_tdata[7:0], m_tdata[9:8], m_tdata[13:10],
                       m_tdata[23:14], m_tdata[33:24], m_tdata[39:34]);
            end
          end
        end
      end
    end
    n_pending = due_results.size();
  end

endmodule

### tb/tb_crc16_framed_packet_receiver.sv
// ----------------------------------------------------------------------------
// tb_crc16_framed_packet_receiver
// Stimulus and verdict for the framed packet receiver: directed words, long
// frames, then random frames, broken frames, noise and ticks under several
// register settings and stall patterns. Checking sits in crc16_frame_checker.
// ----------------------------------------------------------------------------
module tb_crc16_framed_packet_receiver;
  timeunit 1ns;
  timeprecision 1ps;
  import crcfr_pkg::*;

  localparam int         CycleLimit = 20000;
  localparam logic [1:0] RegSpare   = 2'd3;  // beyond the register list, ignored

  logic        clk;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = RegPreamble;
  logic [15:0] cfg_data  = 16'd0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = 8'd0;
  logic        s_tuser   = 1'b0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [39:0] m_tdata;
  logic [2:0]  m_tuser;

  int          fail_count;
  int          pending;
  int          checked;
  logic [15:0] frame_crc;

  int          send_idle = 20;
  int          recv_idle = 55;
  int          tick_pct  = 0;
  logic [7:0]  pre_cur   = 8'h00;
  logic [15:0] tmo_cur   = TimeoutReset;
  int          words_sent = 0;
  int          settings_used = 1;
  int          frames_sent = 0;
  int          frames_bad = 0;
  int          frames_cut = 0;
  int          cycles = 0;

  crc16_framed_packet_receiver DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  crc16_frame_checker frame_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .frame_crc  (frame_crc)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_tready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle);
  end

  task automatic put_word(input logic fn, input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic maybe_tick();
    if ($urandom_range(99) < tick_pct) put_word(1'b1, 8'($urandom));
  endtask

  // preamble, header, length word, payload, trailer; trunc drops the tail
  task automatic send_frame(input logic [7:0] hdr, input logic [7:0] lo,
                            input bit good, input bit trunc);
    int          n;
    logic [1:0]  hm1;
    logic [15:0] tr;
    frames_sent++;
    put_word(1'b0, pre_cur);
    maybe_tick();
    put_word(1'b0, hdr);
    maybe_tick();
    n = 0;
    if (hdr[1:0] != 2'd0) begin
      put_word(1'b0, lo);
      maybe_tick();
      hm1 = hdr[1:0] - 2'd1;
      n   = {hm1, lo} + 1;
      if (n > MaxPayload) n = MaxPayload;
    end
    if (trunc) begin
      frames_cut++;
      n = (n == 0) ? 0 : $urandom_range(n - 1);
    end
    for (int i = 0; i < n; i++) begin
      put_word(1'b0, 8'($urandom));
      maybe_tick();
    end
    if (trunc) return;
    // trailer taken from the checker's running CRC once the last byte is in
    tr = frame_crc;
    if (!good) begin
      tr = tr ^ (16'd1 << $urandom_range(15));
      frames_bad++;
    end
    put_word(1'b0, tr[15:8]);
    maybe_tick();
    put_word(1'b0, tr[7:0]);
  endtask

  task automatic send_noise(input int n);
    logic [7:0] b;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) < 3) begin
        put_word(1'b1, 8'($urandom));
      end else begin
        b = 8'($urandom);
        if ($urandom_range(7) == 0) b = pre_cur;
        put_word(1'b0, b);
      end
    end
  endtask

  task automatic random_unit();
    int         pick;
    int         r;
    logic [7:0] hdr;
    logic [7:0] lo;
    logic [7:0] b;
    pick = $urandom_range(99);
    hdr  = 8'($urandom);
    r    = $urandom_range(99);
    if (r < 20)      hdr[1:0] = 2'd0;
    else if (r < 97) hdr[1:0] = 2'd1;
    else             hdr[1:0] = 2'($urandom_range(3, 2));
    lo = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(7));
    if (pick < 65) begin
      if ($urandom_range(2) == 0) begin
        b = 8'($urandom);
        if (b == pre_cur) b = ~b;
        put_word(1'b0, b);
      end
      send_frame(hdr, lo, $urandom_range(4) != 0, 1'b0);
    end else if (pick < 75) begin
      send_frame(hdr, lo, 1'b1, 1'b1);
      // when the timeout is short, run the timer out so the parser hunts again
      if (tmo_cur <= 64) repeat (tmo_cur) put_word(1'b1, 8'($urandom));
    end else if (pick < 88) begin
      send_noise($urandom_range(6, 1));
    end else begin
      repeat ($urandom_range(4, 1)) put_word(1'b1, 8'($urandom));
    end
  endtask

  // stop sending and let every outstanding result drain
  task automatic settle(input int gap);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (gap) @(negedge clk);
  endtask

  task automatic load_regs(input logic [7:0] pre, input logic [15:0] tmo, input logic garb);
    logic [15:0] junk;
    settle(4);
    junk = 16'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= RegPreamble;
    cfg_data  <= {junk[15:8], pre};
    @(negedge clk);
    cfg_index <= RegTimeout;
    cfg_data  <= tmo;
    @(negedge clk);
    cfg_index <= RegGarbage;
    cfg_data  <= {junk[14:0], garb};
    @(negedge clk);
    cfg_index <= RegSpare;
    cfg_data  <= ~junk;
    @(negedge clk);
    cfg_we  <= 1'b0;
    pre_cur  = pre;
    tmo_cur  = tmo;
    settings_used++;
  endtask

  task automatic run_random(input int n);
    int stop_at;
    stop_at = words_sent + n;
    while (words_sent < stop_at) random_unit();
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // reset defaults: preamble 0, timeout 1000, garbage not reported
    put_word(1'b1, 8'hFF);                // tick with timer idle
    put_word(1'b0, 8'hFF);                // passthrough
    put_word(1'b0, 8'h7E);
    send_frame(8'hFC, 8'h00, 1'b1, 1'b0); // preamble after garbage, empty frame
    send_frame(8'h01, 8'h00, 1'b0, 1'b0); // one byte payload, bad trailer
    send_frame(8'h41, 8'h02, 1'b1, 1'b0);
    put_word(1'b0, 8'h00);                // preamble then tick inside frame
    put_word(1'b1, 8'h00);
    put_word(1'b0, 8'h80);
    put_word(1'b0, 8'h00);
    put_word(1'b0, 8'h00);                // trailer mismatch
    put_word(1'b1, 8'hAA);

    load_regs(8'hA5, 16'hFFFF, 1'b1);
    tick_pct = 5;
    put_word(1'b0, 8'h3C);
    send_frame(8'h10, 8'h03, 1'b1, 1'b0); // reported garbage
    run_random(150);

    load_regs(8'($urandom), 16'd1, 1'b0);
    tick_pct = 3;
    send_frame(8'h05, 8'h01, 1'b1, 1'b1);
    put_word(1'b1, 8'h55);                // first tick times out
    put_word(1'b1, 8'h55);
    // longest decoded length, cut short by the timer
    put_word(1'b0, pre_cur);
    put_word(1'b0, 8'h07);
    put_word(1'b0, 8'hFF);
    put_word(1'b0, 8'h11);
    put_word(1'b1, 8'h00);
    // 257 byte length, cut short the same way
    put_word(1'b0, pre_cur);
    put_word(1'b0, 8'hBA);
    put_word(1'b0, 8'h00);
    put_word(1'b0, 8'h22);
    put_word(1'b1, 8'h00);
    run_random(80);

    load_regs(8'hFF, 16'd12, 1'b1);
    send_idle = 55;
    recv_idle = 20;
    tick_pct  = 10;
    run_random(130);

    load_regs(8'h00, 16'($urandom_range(200, 20)), 1'b0);
    send_idle = 0;
    recv_idle = 0;
    tick_pct  = 8;
    run_random(130);

    settle(8);
    $display("Summary: %0d words in, %0d result words checked, %0d register settings",
             words_sent, checked, settings_used);
    $display("Summary: %0d frames (%0d bad trailer, %0d truncated), %0d mismatches",
             frames_sent, frames_bad, frames_cut, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
